### rtl/hbhq_pkg.sv
// Shared types and constants for the heightmap bilinear height query block.
`default_nettype none
package hbhq_pkg;
    localparam int unsigned GRID_AW = 16;
    localparam int unsigned GRID_DEPTH = 1 << GRID_AW;
    localparam int unsigned HW = 32;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Z  = 3'd1,
        REG_CELL_SIZE = 3'd2,
        REG_COLS      = 3'd3,
        REG_ROWS      = 3'd4,
        REG_INVALID   = 3'd5
    } t_cfg_reg;

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

    // divider request/response
    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [30:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [32:0] quot;
        logic [15:0] frac;
    } t_div_rsp;
endpackage
`default_nettype wire

### rtl/hbhq_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module hbhq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### rtl/hbhq_div.sv
// Restoring divider: 33-bit offset by a 31-bit divisor, giving a 33-bit quotient and 16 fraction bits.
`default_nettype none
module hbhq_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hbhq_pkg::t_div_req i_req,
    output hbhq_pkg::t_div_rsp      o_rsp
);
    // 49 quotient bits: 33 integer then 16 fraction, one per cycle
    logic [48:0] r_num, n_num;
    logic [31:0] r_rem, n_rem;
    logic [30:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;
    logic [31:0] w_shift;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_shift = {r_rem[30:0], r_num[48]};
        w_trial = {1'b0, w_shift} - {2'b0, r_den};
        if (i_req.start) begin
            n_num  = {i_req.dividend, 16'd0};
            n_rem  = '0;
            n_cnt  = 6'd49;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
            end else begin
                n_rem = w_shift;
            end
            n_num = {r_num[47:0], ~w_trial[32]};
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.divisor;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num[48:16];
    assign o_rsp.frac = r_num[15:0];
endmodule
`default_nettype wire

### rtl/heightmap_bilinear_height_query_top.sv
// Top level of the heightmap bilinear height query block.
// Write word: accepted, stored in the next cycle, then back to idle; no result.
// Query word: the result word follows two divider passes, range check, address, corner reads,
// corner check, three lerps (multiply then add) and output load.
// Early rejects: zero cell size or negative X offset, negative Z offset, counts below two,
// outside grid, empty corner. One item at a time: the next word is taken only in idle.
// A waiting result word holds the core in its final state until that word is taken.
// Synchronous active-low reset restores register defaults; grid RAM is not cleared, and
// each entry must be written before it is read: the user ensures this, the block does not.
`default_nettype none
module heightmap_bilinear_height_query_top #(
    parameter int unsigned MAX_COLUMNS = 256,
    parameter int unsigned MAX_ROWS    = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // cfg write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    // input stream; tuser: kind
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic         s_axis_tuser,
    // tdata: pos_x[31:0], pos_z[63:32], entry_index[79:64], entry_height[111:80]
    input  wire logic [111:0] s_axis_tdata,
    // output stream; tuser: valid_res
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic              m_axis_tuser,
    // tdata: height[31:0]
    output logic [31:0]       m_axis_tdata
);
    localparam int unsigned CW = $clog2(MAX_COLUMNS + 1);
    localparam int unsigned RW = $clog2(MAX_ROWS + 1);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_DIVX  = 12'b000000000010,
        ST_DIVZ  = 12'b000000000100,
        ST_CHK   = 12'b000000001000,
        ST_ADDR  = 12'b000000010000,
        ST_RD    = 12'b000000100000,
        ST_LIM   = 12'b000001000000,
        ST_MUL   = 12'b000010000000,
        ST_ADD   = 12'b000100000000,
        ST_OUT   = 12'b001000000000,
        ST_WRITE = 12'b010000000000,
        ST_REJ   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    // config
    logic signed [31:0] r_org_x, r_org_z, r_inv;
    logic [30:0] r_cell;
    logic [8:0]  r_cols, r_rows;

    // item
    logic signed [32:0] r_dx, r_dz;
    logic [32:0] r_cx, r_cz;
    logic [15:0] r_fx, r_fz;
    logic [CW-1:0] r_ecols;
    logic [RW-1:0] r_erows;
    logic [15:0] r_base;
    logic [1:0]  r_idx;
    logic [2:0]  r_rcnt;
    logic signed [31:0] r_c [4];
    logic signed [31:0] r_a, r_b;
    logic signed [49:0] r_prod;
    logic [1:0]  r_lerp;
    logic signed [31:0] r_bot;

    logic        r_ovalid;
    logic signed [31:0] r_oh;
    logic        r_ov;

    // grid RAM
    logic        w_we;
    logic [15:0] w_addr, r_waddr;
    logic [31:0] r_wdata, w_rdata;

    hbhq_pkg::t_div_req w_dreq;
    hbhq_pkg::t_div_rsp w_drsp;

    hbhq_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    hbhq_ram #(.WIDTH(32), .DEPTH(hbhq_pkg::GRID_DEPTH)) u_grid (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(r_wdata), .o_rdata(w_rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ov;
    assign m_axis_tdata  = r_oh;

    wire w_acc = s_axis_tvalid && s_axis_tready;
    // output register free this cycle: empty or being taken
    wire w_out_free = !r_ovalid || (m_axis_tvalid && m_axis_tready);
    // done pulse only counts once this item started the divider
    wire w_div_done = w_drsp.done && (r_rcnt != 3'd0);

    // effective counts, saturated at the maxima
    wire [CW-1:0] w_ecols = (32'(r_cols) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(r_cols);
    wire [RW-1:0] w_erows = (32'(r_rows) > MAX_ROWS)    ? RW'(MAX_ROWS)    : RW'(r_rows);

    // corner address: base plus column step and/or row step
    always_comb begin
        logic [15:0] off;
        off = '0;
        if (r_idx[0]) off = off + 16'd1;
        if (r_idx[1]) off = off + 16'(r_ecols);
        w_addr = (r_state == ST_WRITE) ? r_waddr : (r_base + off);
    end
    assign w_we = (r_state == ST_WRITE);

    // lerp mult operands: difference times fraction
    wire signed [32:0] w_diff = 33'(r_b) - 33'(r_a);
    wire        [15:0] w_frac = (r_lerp == 2'd2) ? r_fz : r_fx;
    wire signed [63:0] w_lim  = 64'(r_inv) + hbhq_pkg::ONE_Q16;
    wire signed [31:0] w_lerp = 32'(64'(r_a) + 64'(r_prod >>> 16));

    always_comb begin
        n_state = r_state;
        w_dreq  = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = (s_axis_tuser == hbhq_pkg::KIND_WRITE) ? ST_WRITE : ST_DIVX;
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_DIVX: begin
                if (r_rcnt == 3'd0) begin
                    w_dreq.start = 1'b1;
                    w_dreq.dividend = r_dx;
                    w_dreq.divisor = r_cell;
                end
                if (r_cell == '0 || r_dx[32]) n_state = ST_REJ;
                else if (w_div_done) n_state = ST_DIVZ;
            end
            ST_DIVZ: begin
                if (r_rcnt == 3'd0) begin
                    w_dreq.start = 1'b1;
                    w_dreq.dividend = r_dz;
                    w_dreq.divisor = r_cell;
                end
                if (r_dz[32]) n_state = ST_REJ;
                else if (w_div_done) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (r_ecols < CW'(2) || r_erows < RW'(2) ||
                    r_cx >= 33'(r_ecols - CW'(1)) || r_cz >= 33'(r_erows - RW'(1)))
                    n_state = ST_REJ;
                else n_state = ST_ADDR;
            end
            ST_ADDR: n_state = ST_RD;
            ST_RD:   if (r_rcnt == 3'd4) n_state = ST_LIM;
            ST_LIM: begin
                if (64'(r_c[0]) <= w_lim || 64'(r_c[1]) <= w_lim ||
                    64'(r_c[2]) <= w_lim || 64'(r_c[3]) <= w_lim)
                    n_state = ST_REJ;
                else n_state = ST_MUL;
            end
            ST_MUL: n_state = ST_ADD;
            ST_ADD: n_state = (r_lerp == 2'd2) ? ST_OUT : ST_MUL;
            // hold until the output register can take the word
            ST_OUT, ST_REJ: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_org_x  <= '0;
            r_org_z  <= '0;
            r_cell   <= 31'd65536;
            r_cols   <= 9'd256;
            r_rows   <= 9'd256;
            r_inv    <= -32'sd65536000;
            r_rcnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hbhq_pkg::REG_ORIGIN_X:  r_org_x <= i_cfg_data;
                    hbhq_pkg::REG_ORIGIN_Z:  r_org_z <= i_cfg_data;
                    hbhq_pkg::REG_CELL_SIZE: r_cell  <= i_cfg_data[30:0];
                    hbhq_pkg::REG_COLS:      r_cols  <= i_cfg_data[8:0];
                    hbhq_pkg::REG_ROWS:      r_rows  <= i_cfg_data[8:0];
                    hbhq_pkg::REG_INVALID:   r_inv   <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == ST_OUT || r_state == ST_REJ) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            // read counter doubles as divider-started flag
            if ((r_state == ST_DIVX || r_state == ST_DIVZ)) begin
                r_rcnt <= w_div_done ? 3'd0 : 3'd1;
            end else if (r_state == ST_RD || r_state == ST_ADDR) begin
                r_rcnt <= (r_state == ST_ADDR) ? 3'd0 : r_rcnt + 3'd1;
            end else begin
                r_rcnt <= '0;
            end
        end
        // datapath
        if (w_acc) begin
            r_dx    <= 33'(signed'(s_axis_tdata[31:0])) - 33'(r_org_x);
            r_dz    <= 33'(signed'(s_axis_tdata[63:32])) - 33'(r_org_z);
            r_waddr <= s_axis_tdata[79:64];
            r_wdata <= s_axis_tdata[111:80];
            r_ecols <= w_ecols;
            r_erows <= w_erows;
        end
        if (w_div_done && r_state == ST_DIVX) begin
            r_cx <= w_drsp.quot; r_fx <= w_drsp.frac;
        end
        if (w_div_done && r_state == ST_DIVZ) begin
            r_cz <= w_drsp.quot; r_fz <= w_drsp.frac;
        end
        if (r_state == ST_ADDR) begin
            r_base <= 16'(r_cz[15:0] * 16'(r_ecols)) + r_cx[15:0];
            r_idx  <= 2'd0;
        end
        if (r_state == ST_RD) begin
            r_idx <= r_idx + 2'd1;
            if (r_rcnt != 3'd0) r_c[r_rcnt[1:0] - 2'd1] <= w_rdata;
        end
        if (r_state == ST_LIM) begin
            r_lerp <= 2'd0;
            r_a <= r_c[0]; r_b <= r_c[1];
        end
        if (r_state == ST_MUL) begin
            r_prod <= 50'(w_diff * signed'({1'b0, w_frac}));
        end
        if (r_state == ST_ADD) begin
            r_lerp <= r_lerp + 2'd1;
            if (r_lerp == 2'd0) begin
                r_bot <= w_lerp; r_a <= r_c[2]; r_b <= r_c[3];
            end else if (r_lerp == 2'd1) begin
                r_a <= r_bot; r_b <= w_lerp;
            end
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_oh <= w_lerp; r_ov <= 1'b1;
        end
        if (r_state == ST_REJ && w_out_free) begin
            r_oh <= r_inv; r_ov <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### tb/heightmap_bilinear_height_query_checker.sv
// Checker: tracks grid and registers, predicts each query word, compares results.
`timescale 1ns / 100ps
module heightmap_bilinear_height_query_checker #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    input  wire logic         i_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic         i_in_kind,
    input  wire logic [111:0] i_in_data,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic         i_out_ok,
    input  wire logic [31:0]  i_out_height,
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic [31:0] height;
        logic        ok;
    } t_height_res;

    logic signed [31:0] org_x, org_z, inv_h;
    logic [30:0]        cell_sz;
    logic [8:0]         col_cnt, row_cnt;
    logic [31:0]        grid_mem [hbhq_pkg::GRID_DEPTH];
    t_height_res        height_q [$];

    // split an offset into cell and Q0.16 fraction; 0 when below zero
    function automatic bit split_offset(input longint d, output longint cell_idx,
                                        output longint frac);
        longint unsigned ud, rem;
        if (d < 0) return 0;
        ud       = d;
        cell_idx = ud / cell_sz;
        rem      = ud % cell_sz;
        frac     = (rem << 16) / cell_sz;
        return 1;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + ((f * (b - a)) >>> 16);
    endfunction

    function automatic longint corner(input longint r, input longint c, input longint n);
        logic [15:0] addr;
        addr = 16'(r * n + c);
        return longint'($signed(grid_mem[addr]));
    endfunction

    function automatic t_height_res interp_height(input logic [31:0] px,
                                                  input logic [31:0] pz);
        t_height_res  res;
        longint cols, rows, cx, cz, fx, fz, lim, bl, br, tl, tr;
        res.height = inv_h;
        res.ok     = 1'b0;
        cols = (col_cnt > MAX_COLUMNS) ? MAX_COLUMNS : col_cnt;
        rows = (row_cnt > MAX_ROWS) ? MAX_ROWS : row_cnt;
        if (cell_sz == 0) return res;
        if (!split_offset(longint'($signed(px)) - longint'(org_x), cx, fx)) return res;
        if (!split_offset(longint'($signed(pz)) - longint'(org_z), cz, fz)) return res;
        if (cx >= cols - 1 || cz >= rows - 1) return res;
        bl  = corner(cz, cx, cols);
        br  = corner(cz, cx + 1, cols);
        tl  = corner(cz + 1, cx, cols);
        tr  = corner(cz + 1, cx + 1, cols);
        lim = longint'(inv_h) + hbhq_pkg::ONE_Q16;
        if (bl <= lim || br <= lim || tl <= lim || tr <= lim) return res;
        res.height = 32'(blend(blend(bl, br, fx), blend(tl, tr, fx), fz));
        res.ok     = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_height_res exp_r;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            org_x   <= '0;
            org_z   <= '0;
            cell_sz <= 31'd65536;
            col_cnt <= 9'd256;
            row_cnt <= 9'd256;
            inv_h   <= -32'sd65536000;
            height_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (hbhq_pkg::t_cfg_reg'(i_cfg_index))
                    hbhq_pkg::REG_ORIGIN_X:  org_x   <= i_cfg_data;
                    hbhq_pkg::REG_ORIGIN_Z:  org_z   <= i_cfg_data;
                    hbhq_pkg::REG_CELL_SIZE: cell_sz <= i_cfg_data[30:0];
                    hbhq_pkg::REG_COLS:      col_cnt <= i_cfg_data[8:0];
                    hbhq_pkg::REG_ROWS:      row_cnt <= i_cfg_data[8:0];
                    hbhq_pkg::REG_INVALID:   inv_h   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_kind == hbhq_pkg::KIND_WRITE)
                    grid_mem[i_in_data[79:64]] <= i_in_data[111:80];
                else
                    height_q.push_back(interp_height(i_in_data[31:0], i_in_data[63:32]));
            end
            if (i_out_valid && i_out_ready) begin
                if (height_q.size() == 0) begin
                    $error("unexpected result word: height %h valid_res %b",
                           i_out_height, i_out_ok);
                    errs++;
                end else begin
                    exp_r = height_q.pop_front();
                    if (exp_r.height !== i_out_height) begin
                        $error("height: expected %h actual %h", exp_r.height, i_out_height);
                        errs++;
                    end
                    if (exp_r.ok !== i_out_ok) begin
                        $error("valid_res: expected %b actual %b", exp_r.ok, i_out_ok);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= height_q.size();
        end
    end
endmodule

### tb/heightmap_bilinear_height_query_top_test.sv
// Testbench top: stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 100ps
module heightmap_bilinear_height_query_top_test;

    localparam int IDLE_LIMIT = 5000;   // cycles with no handshake at all
    localparam int DRAIN_WAIT = 300;    // past worst query latency
    localparam int HOLD_LEN   = 800;    // long receiver hold-off
    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 240;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tuser = 1'b0;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tready = 1'b0;
    logic         o_cfg_ready, s_axis_tready, m_axis_tvalid, m_axis_tuser;
    logic [31:0]  m_axis_tdata;
    int           fail_count, pending;

    // local copy of the register file, used only to aim queries and writes and to pick heights
    logic signed [31:0] cur_ox, cur_oz, cur_inv;
    logic [30:0]        cur_cs;
    int                 cur_cols, cur_rows;

    // entries loaded so far; queries never read one that is not
    bit  written [hbhq_pkg::GRID_DEPTH];

    int  burst_left = 0;
    int  sent = 0;
    bit  hold_req = 0;
    int  idle_cnt = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    heightmap_bilinear_height_query_top i_dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tuser, .m_axis_tdata
    );

    heightmap_bilinear_height_query_checker i_chk (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_kind(s_axis_tuser), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_ok(m_axis_tuser), .i_out_height(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: randomly chosen stall modes; one long hold-off on request.
    always @(posedge i_clk) begin
        static int mode = 0, tick = 0, hold_cnt = 0;
        static bit hold_done = 0;
        tick++;
        if (tick % 64 == 0) mode = $urandom_range(0, 3);
        if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_cnt  = HOLD_LEN;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Watchdog: any word moving on any channel resets the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("heightmap_bilinear_height_query_top: mismatch");
            $finish;
        end
    end

    // One input word; bursts of random length separated by random gaps.
    task automatic send_word(input logic kind, input logic [111:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        burst_left--;
        sent++;
    endtask

    task automatic write_entry(input logic [15:0] idx, input logic [31:0] h);
        written[idx] = 1'b1;
        send_word(hbhq_pkg::KIND_WRITE, {h, idx, 32'($urandom), 32'($urandom)});
    endtask

    // Grid addresses a query reads under the current settings; 0 if it is rejected first.
    function automatic bit corner_addrs(input logic [31:0] px, input logic [31:0] pz,
                                        output int a [4]);
        longint dx, dz, cx, cz;
        if (cur_cs == 0) return 0;
        dx = longint'($signed(px)) - longint'(cur_ox);
        dz = longint'($signed(pz)) - longint'(cur_oz);
        if (dx < 0 || dz < 0) return 0;
        cx = dx / longint'(cur_cs);
        cz = dz / longint'(cur_cs);
        if (cx >= cur_cols - 1 || cz >= cur_rows - 1) return 0;
        a[0] = int'(16'(cz * cur_cols + cx));
        a[1] = int'(16'(cz * cur_cols + cx + 1));
        a[2] = int'(16'((cz + 1) * cur_cols + cx));
        a[3] = int'(16'((cz + 1) * cur_cols + cx + 1));
        return 1;
    endfunction

    // Load any corner the query would read that has not been loaded yet, then send the query.
    task automatic query_at(input logic [31:0] px, input logic [31:0] pz);
        int a [4];
        if (corner_addrs(px, pz, a)) begin
            for (int k = 0; k < 4; k++)
                if (!written[a[k]]) write_entry(16'(a[k]), pick_height());
        end
        send_word(hbhq_pkg::KIND_QUERY, {32'($urandom), 16'($urandom), pz, px});
    endtask

    // Lower valid and let every expected result arrive, plus write latency.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(input hbhq_pkg::t_cfg_reg idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] ox, input logic [31:0] oz,
                             input logic [31:0] cs, input logic [8:0] cols,
                             input logic [8:0] rows, input logic [31:0] inv);
        drain();
        // upper bits of narrow registers carry junk that must be dropped
        cfg_write(hbhq_pkg::REG_ORIGIN_X, ox);
        cfg_write(hbhq_pkg::REG_ORIGIN_Z, oz);
        cfg_write(hbhq_pkg::REG_CELL_SIZE, cs);
        cfg_write(hbhq_pkg::REG_COLS, {23'($urandom), cols});
        cfg_write(hbhq_pkg::REG_ROWS, {23'($urandom), rows});
        cfg_write(hbhq_pkg::REG_INVALID, inv);
        cur_ox = ox; cur_oz = oz; cur_cs = cs[30:0]; cur_inv = inv;
        cur_cols = (cols > 256) ? 256 : cols;
        cur_rows = (rows > 256) ? 256 : rows;
    endtask

    // Mostly moderate heights, some at or just above the empty mark, some full range.
    function automatic logic [31:0] pick_height();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return cur_inv;
        if (r == 1) return cur_inv + 32'd65536;
        if (r == 2) return cur_inv + 32'd65537;
        if (r == 3) return $urandom;
        return 32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
    endfunction

    // Aim a coordinate at a cell, occasionally just past the last one.
    function automatic logic [31:0] aim(input logic signed [31:0] org, input int n);
        longint c, f;
        c = $urandom_range(0, (n > 1) ? n - 1 : 1);
        f = (cur_cs == 0) ? 0 : longint'($urandom) % cur_cs;
        return 32'(longint'(org) + c * cur_cs + f);
    endfunction

    initial begin
        int r, base;
        bit paused;
        paused = 0;
        cur_ox = 0; cur_oz = 0; cur_cs = 31'd65536; cur_inv = -32'sd65536000;
        cur_cols = 256; cur_rows = 256;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under reset settings
        query_at(32'h0000_0000, 32'h0000_0000);
        query_at(32'h00FE_FFFF, 32'h00FE_FFFF);        // last cell, top fraction
        query_at(32'h00FF_0000, 32'h0000_0000);        // one past the last cell in X
        query_at(32'h0000_0000, 32'h00FF_0000);        // one past in Z
        query_at(32'hFFFF_FFFF, 32'h0000_8000);        // negative offset
        query_at(32'h0000_8000, 32'h8000_0000);
        query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query_at(32'h8000_0000, 32'h8000_0000);
        write_entry(16'h0000, 32'h7FFF_FFFF);
        write_entry(16'h0001, 32'h8000_0000);
        write_entry(16'h0100, 32'h0001_0000);
        write_entry(16'h0101, cur_inv + 32'd65537);   // just above the empty mark
        query_at(32'h0000_4000, 32'h0000_C000);
        write_entry(16'h0001, cur_inv + 32'd65536);   // exactly at threshold
        query_at(32'h0000_4000, 32'h0000_C000);
        write_entry(16'hFFFF, 32'h8000_0000);
        write_entry(16'h0001, 32'h7FFF_FFFF);
        query_at(32'h0000_FFFF, 32'h0000_0001);
        query_at(32'h00FE_8000, 32'h00FE_8000);
        configure(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 9'd256, 9'd256, cur_inv);
        query_at(32'h0000_8000, 32'h0000_8000);        // zero cell size
        configure(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 9'd1, 9'd0, cur_inv);
        query_at(32'h0000_0000, 32'h0000_0000);        // counts below two

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(32'(-32'sd65536 * 5), 32'h0003_0000, 32'h0001_0000,
                             9'd16, 9'd12, -32'sd65536000);
                1: configure(32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                             9'd2, 9'd2, 32'h8000_0000);
                2: configure($urandom, $urandom, 32'h8000_0000, 9'd8, 9'd8,
                             $urandom);                           // cell size zero
                3: configure(32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                             9'd256, 9'd256, 32'h7FFF_FFFF);
                4: configure(32'h0000_0000, 32'hFFF0_0000, 32'h0000_4000,
                             9'd300, 9'd511, -32'sd65536000);     // saturating counts
                5: configure($urandom, $urandom, $urandom_range(1, 32'h0010_0000),
                             9'd0, 9'd1, $urandom);
                default: configure($urandom, $urandom, $urandom_range(1, 32'h0010_0000),
                                   9'($urandom_range(2, 40)), 9'($urandom_range(2, 40)),
                                   32'($signed($urandom_range(0, 32'h07FF_FFFF))
                                       - 32'sh0400_0000));
            endcase
            base = sent;
            while (sent - base < PER_PHASE) begin
                if (ph == 0 && !hold_req && sent - base >= PER_PHASE / 3) hold_req = 1;
                if (ph == 0 && !paused && sent - base >= 2 * PER_PHASE / 3) begin
                    // sender waits for the pipeline to empty out completely
                    paused = 1;
                    s_axis_tvalid <= 1'b0;
                    burst_left = 0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                r = $urandom_range(0, 99);
                if (r < 60)
                    query_at(aim(cur_ox, cur_cols), aim(cur_oz, cur_rows));
                else if (r < 75)
                    query_at($urandom, $urandom);
                else if (r < 95)
                    write_entry(16'($urandom_range(0, cur_cols * cur_rows - 1)),
                                pick_height());
                else
                    write_entry(16'($urandom), pick_height());
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("heightmap_bilinear_height_query_top: match");
        else
            $display("heightmap_bilinear_height_query_top: mismatch");
        $finish;
    end
endmodule
